// ----- sv/b58_pkg.sv -----
package b58_pkg;

    localparam int DEF_MAX_BYTES = 32;
    localparam int DEF_DIGITS    = 45;
    localparam int MAX_RESULTS   = 45;
    localparam int BASE          = 58;

    // floor(2^20 / 58); the quotient estimate is low by at most one.
    localparam logic [14:0] RECIP_58  = 15'd18078;
    localparam int          RECIP_SHR = 20;

    localparam logic [6:0] SYM_ONE = 7'h31;

    typedef struct packed {
        logic take;
        logic idx_clr;
        logic idx_inc;
        logic idx_dec;
        logic idx_top;
        logic rd;
        logic fold;
        logic prep;
        logic ld_one;
        logic ld_dig;
        logic ld_ovf;
        logic clr;
    } t_cmd;

    typedef struct packed {
        logic fold_ok;
        logic last_digit;
        logic eom;
        logic ovf;
        logic out_free;
        logic zeros_left;
        logic last_out;
        logic digits_none;
    } t_sts;

    // Maps a base-58 digit to its character; the alphabet skips 0, I, O and l.
    function automatic logic [6:0] alpha(input logic [5:0] d);
        logic [6:0] v;
        v = {1'b0, d};
        if (d < 6'd9) begin
            return 7'h31 + v;
        end else if (d < 6'd17) begin
            return 7'h41 + v - 7'd9;
        end else if (d < 6'd22) begin
            return 7'h4A + v - 7'd17;
        end else if (d < 6'd33) begin
            return 7'h50 + v - 7'd22;
        end else if (d < 6'd44) begin
            return 7'h61 + v - 7'd33;
        end else begin
            return 7'h6D + v - 7'd44;
        end
    endfunction

endpackage

// ----- sv/b58_ram.sv -----
module b58_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 45
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/b58_dp.sv -----
module b58_dp #(
    parameter int MAX_BYTES = b58_pkg::DEF_MAX_BYTES,
    parameter int DIGITS    = b58_pkg::DEF_DIGITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    input  b58_pkg::t_cmd i_cmd,
    output b58_pkg::t_sts o_sts,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [6:0]    o_symbol,
    output logic          o_last,
    output logic          o_too_long
);
    import b58_pkg::*;

    localparam int IW  = $clog2(DIGITS);
    localparam int CW  = $clog2(MAX_BYTES + 2);
    localparam int ZW  = $clog2(MAX_BYTES + 1);
    localparam int NW  = $clog2(MAX_RESULTS + 1);
    localparam int MW  = (ZW > IW) ? ZW : IW;
    localparam int SW  = ((MW > NW) ? MW : NW) + 1;

    logic [CW-1:0] r_count;
    logic [ZW-1:0] r_zr;
    logic          r_seen;
    logic          r_fresh;
    logic          r_eom;
    logic [8:0]    r_carry;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] n_idx;
    logic [IW-1:0] r_top;
    logic          r_any;
    logic [NW-1:0] r_total;
    logic [NW-1:0] r_n;
    logic          r_valid;
    logic [6:0]    r_symbol;
    logic          r_last;
    logic          r_too_long;

    logic [5:0]    w_rdata;
    logic [5:0]    w_d;
    logic [13:0]   w_t;
    logic [28:0]   w_prod;
    logic [8:0]    w_q0;
    logic [13:0]   w_r0;
    logic [5:0]    w_rem;
    logic [8:0]    w_quo;
    logic [SW-1:0] w_sum;
    logic [NW-1:0] w_total;
    logic          w_out_free;

    // One base-58 digit step: t = digit * 256 + carry, split into t % 58 and t / 58.
    always_comb begin
        w_d    = r_fresh ? 6'd0 : w_rdata;
        w_t    = {w_d, 8'h00} + 14'(r_carry);
        w_prod = 29'(w_t) * 29'(RECIP_58);
        w_q0   = w_prod[RECIP_SHR +: 9];
        w_r0   = w_t - 14'(14'(w_q0) * 14'(BASE));
        if (w_r0 >= 14'(BASE)) begin
            w_rem = 6'(w_r0 - 14'(BASE));
            w_quo = w_q0 + 9'd1;
        end else begin
            w_rem = 6'(w_r0);
            w_quo = w_q0;
        end
    end

    always_comb begin
        w_sum = SW'(r_zr) + (r_any ? (SW'(r_top) + SW'(1)) : SW'(0));
        if (w_sum >= SW'(MAX_RESULTS)) begin
            w_total = NW'(MAX_RESULTS);
        end else begin
            w_total = NW'(w_sum);
        end
    end

    always_comb begin
        if (i_cmd.idx_clr) begin
            n_idx = '0;
        end else if (i_cmd.idx_inc) begin
            n_idx = r_idx + IW'(1);
        end else if (i_cmd.idx_dec) begin
            n_idx = r_idx - IW'(1);
        end else if (i_cmd.idx_top) begin
            n_idx = r_top;
        end else begin
            n_idx = r_idx;
        end
    end

    b58_ram #(
        .WIDTH(6),
        .DEPTH(DIGITS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.fold),
        .i_waddr(r_idx),
        .i_wdata(w_rem),
        .i_re   (i_cmd.rd),
        .i_raddr(n_idx),
        .o_rdata(w_rdata)
    );

    assign w_out_free = !r_valid || i_ready;

    always_comb begin
        o_sts.fold_ok     = r_count < CW'(MAX_BYTES);
        o_sts.last_digit  = r_idx == IW'(DIGITS - 1);
        o_sts.eom         = r_eom;
        o_sts.ovf         = r_count > CW'(MAX_BYTES);
        o_sts.out_free    = w_out_free;
        o_sts.zeros_left  = (SW'(r_n) < SW'(r_zr)) && (r_n < r_total);
        o_sts.last_out    = (SW'(r_n) + SW'(1)) == SW'(r_total);
        o_sts.digits_none = !r_any;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_zr    <= '0;
            r_seen  <= 1'b0;
            r_fresh <= 1'b1;
        end else if (i_cmd.clr) begin
            r_count <= '0;
            r_zr    <= '0;
            r_seen  <= 1'b0;
            r_fresh <= 1'b1;
        end else if (i_cmd.take) begin
            if (r_count <= CW'(MAX_BYTES)) begin
                r_count <= r_count + CW'(1);
            end
            if (o_sts.fold_ok && !r_seen) begin
                if (i_byte == 8'd0) begin
                    r_zr <= r_zr + ZW'(1);
                end else begin
                    r_seen <= 1'b1;
                end
            end
        end else if (i_cmd.fold && o_sts.last_digit) begin
            r_fresh <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.take) begin
            r_carry <= 9'(i_byte);
            r_eom   <= i_last;
            r_any   <= 1'b0;
        end
        if (i_cmd.fold) begin
            r_carry <= w_quo;
            if (w_rem != 6'd0) begin
                r_top <= r_idx;
                r_any <= 1'b1;
            end
        end
        if (i_cmd.prep) begin
            r_total <= w_total;
            r_n     <= '0;
        end else if (i_cmd.ld_one || i_cmd.ld_dig) begin
            r_n <= r_n + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.ld_one || i_cmd.ld_dig || i_cmd.ld_ovf) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_one) begin
            r_symbol   <= SYM_ONE;
            r_last     <= o_sts.last_out;
            r_too_long <= 1'b0;
        end else if (i_cmd.ld_dig) begin
            r_symbol   <= alpha(w_rdata);
            r_last     <= o_sts.last_out;
            r_too_long <= 1'b0;
        end else if (i_cmd.ld_ovf) begin
            r_symbol   <= 7'd0;
            r_last     <= 1'b1;
            r_too_long <= 1'b1;
        end
    end

    assign o_valid    = r_valid;
    assign o_symbol   = r_symbol;
    assign o_last     = r_last;
    assign o_too_long = r_too_long;

endmodule

// ----- sv/b58_ctrl.sv -----
module b58_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  b58_pkg::t_sts i_sts,
    output b58_pkg::t_cmd o_cmd
);
    import b58_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FOLD  = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_OVF   = 3'd3;
    localparam logic [2:0] S_ZEROS = 3'd4;
    localparam logic [2:0] S_DIGIT = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_sts.fold_ok) begin
                        o_cmd.idx_clr = 1'b1;
                        o_cmd.rd      = 1'b1;
                        n_state       = S_FOLD;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                if (i_sts.last_digit) begin
                    n_state = S_CHK;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    o_cmd.rd      = 1'b1;
                end
            end
            S_CHK: begin
                if (!i_sts.eom) begin
                    n_state = S_IDLE;
                end else if (i_sts.ovf) begin
                    n_state = S_OVF;
                end else begin
                    o_cmd.prep = 1'b1;
                    n_state    = S_ZEROS;
                end
            end
            S_OVF: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_ovf = 1'b1;
                    o_cmd.clr    = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ZEROS: begin
                if (i_sts.zeros_left) begin
                    if (i_sts.out_free) begin
                        o_cmd.ld_one = 1'b1;
                        if (i_sts.last_out) begin
                            o_cmd.clr = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                end else if (i_sts.digits_none) begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.idx_top = 1'b1;
                    o_cmd.rd      = 1'b1;
                    n_state       = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_dig = 1'b1;
                    if (i_sts.last_out) begin
                        o_cmd.clr = 1'b1;
                        n_state   = S_IDLE;
                    end else begin
                        o_cmd.idx_dec = 1'b1;
                        o_cmd.rd      = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/base58_encoder.sv -----
// Base58 encoder for byte messages.
// Input stream: one message byte per beat, most significant byte first, with
// tlast on the final byte. Output stream: one ASCII character per beat, with
// tlast on the final character; tuser is set on the single beat that reports
// a message longer than MAX_BYTES.
// Each byte is folded into a digit store held in a small RAM, one base-58
// digit per cycle, so an accepted byte holds off the next one until every
// digit is folded and the check state has run; later bytes past MAX_BYTES
// skip the fold. After the check state that ends the final byte the block
// sends one '1' per leading zero byte, reads the first digit, then sends the
// digits, one beat per cycle while the receiver is ready, 45 in all at most.
// The next message is accepted once the last character sits in the output
// register; the input is not ready while a message is being sent.
// A stalled receiver holds the output register, and the sequencer waits
// until it is free, so nothing is lost. Reset empties the output register
// and starts a fresh message; the digit RAM needs no clearing pass, since
// the first byte of a message overwrites every digit.
module base58_encoder #(
    parameter int MAX_BYTES = b58_pkg::DEF_MAX_BYTES,
    parameter int DIGITS    = b58_pkg::DEF_DIGITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,  // [7:0] data_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,  // [6:0] symbol, [7] zero
    output logic       o_m_axis_tlast,
    output logic       o_m_axis_tuser   // [0] too_long
);
    import b58_pkg::*;

    t_cmd       w_cmd;
    t_sts       w_sts;
    logic [6:0] w_symbol;

    b58_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid),
        .o_ready(o_s_axis_tready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    b58_dp #(
        .MAX_BYTES(MAX_BYTES),
        .DIGITS   (DIGITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_symbol  (w_symbol),
        .o_last    (o_m_axis_tlast),
        .o_too_long(o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {1'b0, w_symbol};

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    import b58_pkg::*;

    typedef struct packed {
        logic [6:0] sym;
        logic       last;
        logic       too_long;
    } t_b58_char;

    // The alphabet with its first character in the top byte.
    localparam logic [8*58-1:0] B58_CHARSET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata = 8'h00;  // [7:0] data_byte
    logic       i_s_axis_tlast = 1'b0;
    logic       i_m_axis_tready = 1'b0;
    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;          // [6:0] symbol, [7] zero
    logic       o_m_axis_tlast;
    logic       o_m_axis_tuser;          // [0] too_long

    base58_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    t_b58_char  expected_chars[$];
    logic [5:0] digit_store[DEF_DIGITS];
    logic [5:0] zero_run = '0;
    logic [5:0] byte_count = '0;
    logic       seen_nonzero = 1'b0;

    int src_idle_pct = 24;
    int dst_idle_pct = 61;
    int rx_hold = 0;
    int errors = 0;
    int beats_checked = 0;
    int bytes_sent = 0;
    int messages_sent = 0;
    int oversized_msgs = 0;

    always #10 i_clk = ~i_clk;

    initial begin
        for (int k = 0; k < DEF_DIGITS; k++) begin
            digit_store[k] = '0;
        end
    end

    // Folds one byte within the length limit into the base-58 digits and, on the
    // final byte, queues the characters the block must send.
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        int carry;
        int t;
        int top;
        int n_ones;
        int n_digits;
        int total;
        int n;
        carry = b;
        if (byte_count < DEF_MAX_BYTES + 1) begin
            byte_count++;
        end
        if (byte_count <= DEF_MAX_BYTES) begin
            if (!seen_nonzero) begin
                if (b == 8'h00) begin
                    zero_run++;
                end else begin
                    seen_nonzero = 1'b1;
                end
            end
            for (int k = 0; k < DEF_DIGITS; k++) begin
                t = digit_store[k] * 256 + carry;
                digit_store[k] = 6'(t % BASE);
                carry = t / BASE;
            end
        end
        if (!eom) begin
            return;
        end
        messages_sent++;
        if (byte_count > DEF_MAX_BYTES) begin
            expected_chars.push_back({7'd0, 1'b1, 1'b1});
            oversized_msgs++;
        end else begin
            top = -1;
            for (int k = DEF_DIGITS - 1; k >= 0 && top < 0; k--) begin
                if (digit_store[k] != 0) begin
                    top = k;
                end
            end
            n_ones = (zero_run < MAX_RESULTS) ? zero_run : MAX_RESULTS;
            n_digits = (top + 1 < MAX_RESULTS - n_ones) ? top + 1 : MAX_RESULTS - n_ones;
            total = n_ones + n_digits;
            n = 0;
            for (int k = 0; k < n_ones; k++) begin
                expected_chars.push_back({SYM_ONE, n == total - 1, 1'b0});
                n++;
            end
            for (int k = top; k > top - n_digits; k--) begin
                expected_chars.push_back({B58_CHARSET[8 * (57 - digit_store[k]) +: 7],
                                          n == total - 1, 1'b0});
                n++;
            end
        end
        for (int k = 0; k < DEF_DIGITS; k++) begin
            digit_store[k] = '0;
        end
        zero_run = '0;
        byte_count = '0;
        seen_nonzero = 1'b0;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tlast  <= eom;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        bytes_sent++;
        encode_byte(b, eom);
    endtask

    task automatic send_random_message();
        int pick;
        int len;
        int zeros;
        int kind;
        logic [7:0] b;
        pick = $urandom_range(99, 0);
        if (pick < 70) begin
            len = $urandom_range(6, 1);
        end else if (pick < 92) begin
            len = $urandom_range(DEF_MAX_BYTES, 7);
        end else begin
            len = $urandom_range(DEF_MAX_BYTES + 4, DEF_MAX_BYTES + 1);
        end
        zeros = ($urandom_range(3, 0) == 0) ? $urandom_range(len, 1) : 0;
        for (int k = 0; k < len; k++) begin
            kind = $urandom_range(9, 0);
            if (k < zeros || kind == 0) begin
                b = 8'h00;
            end else if (kind == 1) begin
                b = 8'hFF;
            end else begin
                b = 8'($urandom_range(255, 0));
            end
            send_byte(b, k == len - 1);
        end
    endtask

    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h39, 1'b1);
        send_byte(8'h3A, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
    endtask

    // Longest messages that still encode, then the first two lengths past the
    // limit.
    task automatic test_length_limits();
        for (int k = 0; k < DEF_MAX_BYTES; k++) begin
            send_byte(8'h00, k == DEF_MAX_BYTES - 1);
        end
        for (int k = 0; k < DEF_MAX_BYTES; k++) begin
            send_byte(8'hFF, k == DEF_MAX_BYTES - 1);
        end
        for (int k = 0; k < DEF_MAX_BYTES; k++) begin
            send_byte((k == 0) ? 8'h00 : 8'hFF, k == DEF_MAX_BYTES - 1);
        end
        for (int k = 0; k < DEF_MAX_BYTES + 1; k++) begin
            send_byte(8'($urandom_range(255, 0)), k == DEF_MAX_BYTES);
        end
        for (int k = 0; k < DEF_MAX_BYTES + 2; k++) begin
            send_byte(8'($urandom_range(255, 0)), k == DEF_MAX_BYTES + 1);
        end
    endtask

    // The receiver stops for a long stretch so that the block backs up into
    // its input while new bytes keep coming.
    task automatic test_output_stall();
        src_idle_pct = 0;
        dst_idle_pct = 0;
        rx_hold <= 3000;
        for (int m = 0; m < 3; m++) begin
            send_random_message();
        end
    endtask

    task automatic test_random_traffic();
        int phase_start;
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 24 : (phase == 1) ? 61 : 0;
            dst_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 24 : 0;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < 15) begin
                send_random_message();
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end
    end

    always @(posedge i_clk) begin : check_beats
        t_b58_char want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_chars.size() == 0) begin
                $error("output beat with no character pending: tdata %0h", o_m_axis_tdata);
                errors++;
            end else begin
                want = expected_chars.pop_front();
                beats_checked++;
                if (o_m_axis_tdata[6:0] !== want.sym) begin
                    $error("symbol: expected %0d, actual %0d", want.sym, o_m_axis_tdata[6:0]);
                    errors++;
                end
                if (o_m_axis_tdata[7] !== 1'b0) begin
                    $error("tdata pad: expected 0, actual %0b", o_m_axis_tdata[7]);
                    errors++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last_symbol: expected %0b, actual %0b", want.last, o_m_axis_tlast);
                    errors++;
                end
                if (o_m_axis_tuser !== want.too_long) begin
                    $error("too_long: expected %0b, actual %0b", want.too_long, o_m_axis_tuser);
                    errors++;
                end
            end
        end
        i_m_axis_tready <= (rx_hold == 0) && ($urandom_range(99, 0) >= dst_idle_pct);
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_length_limits();
        test_output_stall();
        test_random_traffic();
        i_s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (100) @(posedge i_clk);
        $display("Sent %0d messages in %0d bytes and checked %0d output beats.",
                 messages_sent, bytes_sent, beats_checked);
        $display("This included %0d oversized messages, a long output stall and three idle mixes.",
                 oversized_msgs);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
